// File: design/zsqwd_pkg.sv
// Shared types and constants of the zero square window detector.
`default_nettype none
package zsqwd_pkg;

  localparam int unsigned CFG_IDX_W   = 2;
  localparam int unsigned CFG_DATA_W  = 11;
  localparam int unsigned SIDE_CFG_W  = 5;
  localparam int unsigned SIZE_CFG_W  = 11;
  localparam int unsigned POS_W       = 10;
  localparam int unsigned ROW_CAP     = 1024;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_SQUARE_SIDE  = 2'd0,
    CFG_GRID_COLUMNS = 2'd1,
    CFG_GRID_ROWS    = 2'd2,
    CFG_UNUSED       = 2'd3
  } cfg_idx_t;

  localparam logic [SIDE_CFG_W-1:0] RST_SQUARE_SIDE  = 5'd2;
  localparam logic [SIZE_CFG_W-1:0] RST_GRID_COLUMNS = 11'd20;
  localparam logic [SIZE_CFG_W-1:0] RST_GRID_ROWS    = 11'd10;

endpackage
`default_nettype wire

// File: design/zsqwd_ram.sv
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module zsqwd_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     wr_en,
  input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
  input  wire logic [WIDTH-1:0]         wr_data,
  input  wire logic                     rd_en,
  input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic      [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule
`default_nettype wire

// File: design/zero_square_window_detector.sv
// Zero square window detector: raster cell stream in, all-zero square hits out.
// Pipeline: input stage register, then result register, from input transfer to result.
// Throughput: one cell per cycle unless out_stall holds the result; column run memory
// is read on input accept, written on retire, with a back-to-back same-column bypass.
// Reset: synchronous active-low; clears position, row run, pipeline valids and
// restores config (side 2, 20 columns, 10 rows). Column memory is not cleared.
`default_nettype none
module zero_square_window_detector #(
  parameter int unsigned MAX_COLUMNS = 1024,
  parameter int unsigned MAX_SIDE    = 16
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                cfg_wr_en,
  input  wire logic [zsqwd_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  wire logic [zsqwd_pkg::CFG_DATA_W-1:0]    cfg_wr_data,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic                                in_cell_occupied,
  input  wire logic                                in_frame_start,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     out_square_found,
  output logic      [zsqwd_pkg::POS_W-1:0]         out_left_column,
  output logic      [zsqwd_pkg::POS_W-1:0]         out_top_row,
  output logic                                     out_frame_done
);

  localparam int unsigned COL_CAP = (MAX_COLUMNS < 1024) ? MAX_COLUMNS : 1024;
  localparam int unsigned AW      = $clog2(COL_CAP);
  localparam int unsigned SW      = $clog2(MAX_SIDE + 1);
  localparam int unsigned PW      = zsqwd_pkg::POS_W;
  localparam int unsigned ZW      = zsqwd_pkg::SIZE_CFG_W;

  // configuration
  logic [zsqwd_pkg::SIDE_CFG_W-1:0] square_side_r;
  logic [ZW-1:0]                    grid_columns_r;
  logic [ZW-1:0]                    grid_rows_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      square_side_r  <= zsqwd_pkg::RST_SQUARE_SIDE;
      grid_columns_r <= zsqwd_pkg::RST_GRID_COLUMNS;
      grid_rows_r    <= zsqwd_pkg::RST_GRID_ROWS;
    end else if (cfg_wr_en) begin
      case (zsqwd_pkg::cfg_idx_t'(cfg_index))
        zsqwd_pkg::CFG_SQUARE_SIDE: begin
          square_side_r <= cfg_wr_data[zsqwd_pkg::SIDE_CFG_W-1:0];
        end
        zsqwd_pkg::CFG_GRID_COLUMNS: begin
          grid_columns_r <= cfg_wr_data[ZW-1:0];
        end
        zsqwd_pkg::CFG_GRID_ROWS: begin
          grid_rows_r <= cfg_wr_data[ZW-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  logic [SW-1:0] side_w;
  logic [ZW-1:0] cols_w;
  logic [ZW-1:0] rows_w;

  always_comb begin
    if (square_side_r == '0) begin
      side_w = SW'(1);
    end else if (32'(square_side_r) > MAX_SIDE) begin
      side_w = SW'(MAX_SIDE);
    end else begin
      side_w = SW'(square_side_r);
    end
    if (grid_columns_r == '0) begin
      cols_w = ZW'(1);
    end else if (32'(grid_columns_r) > COL_CAP) begin
      cols_w = ZW'(COL_CAP);
    end else begin
      cols_w = grid_columns_r;
    end
    if (grid_rows_r == '0) begin
      rows_w = ZW'(1);
    end else if (32'(grid_rows_r) > zsqwd_pkg::ROW_CAP) begin
      rows_w = ZW'(zsqwd_pkg::ROW_CAP);
    end else begin
      rows_w = grid_rows_r;
    end
  end

  function automatic logic [SW-1:0] sat_inc(input logic [SW-1:0] v);
    if (32'(v) >= MAX_SIDE) begin
      return SW'(MAX_SIDE);
    end
    return v + SW'(1);
  endfunction

  // position and input stage
  logic          in_accept;
  logic          s1_fire;
  logic [PW-1:0] row_r, row_nxt;
  logic [PW-1:0] col_r, col_nxt;
  logic [PW-1:0] r0, c0;
  logic          row_end0, done0;

  logic          s1_valid_r;
  logic          s1_occ_r;
  logic [PW-1:0] s1_row_r;
  logic [PW-1:0] s1_col_r;
  logic          s1_done_r;
  logic          s1_fwd_r;
  logic [SW-1:0] s1_fwd_data_r;

  assign s1_fire   = s1_valid_r && (!out_valid || !out_stall);
  assign in_stall  = s1_valid_r && !s1_fire;
  assign in_accept = in_valid && !in_stall;

  always_comb begin
    r0       = in_frame_start ? '0 : row_r;
    c0       = in_frame_start ? '0 : col_r;
    row_end0 = ({1'b0, c0} + ZW'(1)) >= cols_w;
    done0    = row_end0 && (({1'b0, r0} + ZW'(1)) >= rows_w);
    row_nxt  = r0;
    col_nxt  = c0 + PW'(1);
    if (done0) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (row_end0) begin
      row_nxt = r0 + PW'(1);
      col_nxt = '0;
    end
  end

  // cell retiring from stage 1
  logic [SW-1:0] rd_data;
  logic [SW-1:0] prev_run;
  logic [SW-1:0] vrun;
  logic [SW-1:0] row_run_r, row_run_nxt, row_run_base;
  logic          found;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_r      <= '0;
      col_r      <= '0;
      s1_valid_r <= 1'b0;
    end else begin
      if (in_accept) begin
        row_r      <= row_nxt;
        col_r      <= col_nxt;
        s1_valid_r <= 1'b1;
      end else if (s1_fire) begin
        s1_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_occ_r      <= in_cell_occupied;
      s1_row_r      <= r0;
      s1_col_r      <= c0;
      s1_done_r     <= done0;
      s1_fwd_r      <= s1_fire && (s1_col_r[AW-1:0] == c0[AW-1:0]);
      s1_fwd_data_r <= vrun;
    end
  end

  zsqwd_ram #(
    .WIDTH(SW),
    .DEPTH(COL_CAP)
  ) u_col_runs (
    .clk    (clk),
    .wr_en  (s1_fire),
    .wr_addr(s1_col_r[AW-1:0]),
    .wr_data(vrun),
    .rd_en  (in_accept),
    .rd_addr(c0[AW-1:0]),
    .rd_data(rd_data)
  );

  always_comb begin
    prev_run = s1_fwd_r ? s1_fwd_data_r : rd_data;
    if (s1_occ_r) begin
      vrun = '0;
    end else if (s1_row_r == '0) begin
      vrun = SW'(1);
    end else begin
      vrun = sat_inc(prev_run);
    end
    row_run_base = (s1_col_r == '0) ? '0 : row_run_r;
    row_run_nxt  = (vrun >= side_w) ? sat_inc(row_run_base) : '0;
    found        = row_run_nxt >= side_w;
  end

  // result register
  logic          out_valid_r;
  logic          out_found_r;
  logic [PW-1:0] out_left_r;
  logic [PW-1:0] out_top_r;
  logic          out_done_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      row_run_r   <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (s1_fire) begin
        row_run_r   <= row_run_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_found_r <= found;
      out_left_r  <= found ? (s1_col_r + PW'(1) - PW'(side_w)) : '0;
      out_top_r   <= found ? (s1_row_r + PW'(1) - PW'(side_w)) : '0;
      out_done_r  <= s1_done_r;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_square_found = out_found_r;
  assign out_left_column  = out_left_r;
  assign out_top_row      = out_top_r;
  assign out_frame_done   = out_done_r;

  a_stall_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r)
    else $error("input stalled with empty stage 1");

  a_bypass_on_same_column: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && s1_fire && (s1_col_r[AW-1:0] == c0[AW-1:0])) |=> s1_fwd_r)
    else $error("missing bypass for same-column cell");

  a_result_from_stage1: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(s1_valid_r))
    else $error("result appeared without a cell in stage 1");

  a_frame_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (in_accept && done0) |=> (row_r == '0 && col_r == '0))
    else $error("position not reset after last cell of frame");

endmodule
`default_nettype wire
